>>> hw/rtl/sjf_pkg.sv
// shared types and constants for the shortest-job-first scheduler
package sjf_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned FieldW = 16;
  localparam int unsigned CountW = 5;
  localparam int unsigned SlotW  = 4;

  localparam logic [TimeW-1:0] TimeMax = '1;

  // command codes
  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  // saturating count of unfinished used slots seen by the scan
  localparam logic [1:0] NdNone = 2'd0;
  localparam logic [1:0] NdOne  = 2'd1;
  localparam logic [1:0] NdMany = 2'd2;

  // scan word handed from cell to cell
  typedef struct packed {
    logic              found;
    logic              forced;
    logic [1:0]        nd_cnt;
    logic [FieldW-1:0] arrival;
    logic [FieldW-1:0] burst;
    logic [FieldW-1:0] remaining;
    logic [TimeW-1:0]  response;
    logic [TimeW-1:0]  waiting;
  } tok_t;

  // commit broadcast at the end of a tick
  typedef struct packed {
    logic en;
    logic found;
  } cmt_t;

endpackage

>>> hw/rtl/sjf_nonpreemptive_scheduler.sv
// top level: non-preemptive shortest-job-first scheduler over a chain of job cells
//
// Usage: a command word is taken when start is high and busy is low.
// A load command (cmd_i low) writes arrival and burst into a slot in that
// cycle and gives no result; the next command may follow at once.
// A tick command (cmd_i high) sends a scan word down the row of MAX_JOBS
// cells, one cell per cycle; each cell counts itself if unfinished and
// replaces the candidate if it is the running job or a shorter arrived job.
// In the cycle after the last cell's scan step the winner is committed:
// remaining work, response and waiting counts are updated in all cells at once and the
// result word is registered. result_valid_o is high for exactly one cycle and
// the receiver cannot stall it. busy stays high until the winner is committed,
// so no new command is taken before a tick is through; the tick rate is set by
// the length of the cell chain.
// job_count is written over cfg_valid_i/cfg_ready_o while the block is idle.
// Reset clears time, job count, the running mark and per-slot waiting and
// done state; arrival, burst, remaining are junk until loaded, response until set.
module sjf_nonpreemptive_scheduler #(
  parameter int unsigned MAX_JOBS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic [sjf_pkg::SlotW-1:0]    slot_i,
  input  logic [sjf_pkg::FieldW-1:0]   arrival_time_i,
  input  logic [sjf_pkg::FieldW-1:0]   burst_length_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sjf_pkg::CountW-1:0]   cfg_data_i,
  output logic                         result_valid_o,
  output logic [sjf_pkg::TimeW-1:0]    tick_time_o,
  output logic [sjf_pkg::SlotW-1:0]    running_slot_o,
  output logic                         idle_o,
  output logic                         finished_o,
  output logic [sjf_pkg::TimeW-1:0]    response_time_o,
  output logic [sjf_pkg::TimeW-1:0]    waiting_time_o,
  output logic [sjf_pkg::TimeW-1:0]    turnaround_time_o,
  output logic                         all_done_o
);

  localparam int unsigned IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned CW = (IW > sjf_pkg::SlotW) ? IW : sjf_pkg::SlotW;

  logic [sjf_pkg::CountW-1:0] job_count_q;
  logic [sjf_pkg::TimeW-1:0]  now_q;
  logic                       busy_q, go_q;
  logic                       cur_valid_q;
  logic [IW-1:0]              cur_idx_q;
  logic                       accept, ld_acc, tick_acc;

  logic                       tv      [MAX_JOBS+1];
  sjf_pkg::tok_t              tok     [MAX_JOBS+1];
  logic [IW-1:0]              tok_idx [MAX_JOBS+1];

  sjf_pkg::tok_t              fin_tok;
  logic [IW-1:0]              fin_idx;
  logic                       commit;
  sjf_pkg::cmt_t              cmt;
  logic                       fin;
  logic [sjf_pkg::TimeW:0]    turn;
  logic [sjf_pkg::TimeW-1:0]  tt, rt;

  assign accept   = start && !busy_q;
  assign ld_acc   = accept && (cmd_i == sjf_pkg::CmdLoad);
  assign tick_acc = accept && (cmd_i == sjf_pkg::CmdTick);
  assign busy        = busy_q;
  assign cfg_ready_o = !busy_q;

  // chain head: empty scan word
  assign tv[0]      = go_q;
  assign tok[0]     = '0;
  assign tok_idx[0] = '0;

  assign fin_tok   = tok[MAX_JOBS];
  assign fin_idx   = tok_idx[MAX_JOBS];
  assign commit    = tv[MAX_JOBS];
  assign cmt.en    = commit;
  assign cmt.found = fin_tok.found;

  // row of job cells
  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    sjf_cell #(
      .IW  (IW),
      .IDX (g)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ld_en_i      (ld_acc && (32'(slot_i) == 32'(g))),
      .ld_arrival_i (arrival_time_i),
      .ld_burst_i   (burst_length_i),
      .used_i       (32'(job_count_q) > 32'(g)),
      .cur_hit_i    (cur_valid_q && (cur_idx_q == IW'(g))),
      .sel_hit_i    (fin_tok.found && (fin_idx == IW'(g))),
      .now_i        (now_q),
      .cmt_i        (cmt),
      .tv_i         (tv[g]),
      .tok_i        (tok[g]),
      .tok_idx_i    (tok_idx[g]),
      .tv_o         (tv[g+1]),
      .tok_o        (tok[g+1]),
      .tok_idx_o    (tok_idx[g+1])
    );
  end

  // result of the winning job
  always_comb begin
    fin  = fin_tok.found && (fin_tok.remaining == sjf_pkg::FieldW'(1));
    turn = {1'b0, now_q} + (sjf_pkg::TimeW+1)'(1) - (sjf_pkg::TimeW+1)'(fin_tok.arrival);
    tt   = turn[sjf_pkg::TimeW] ? sjf_pkg::TimeMax : turn[sjf_pkg::TimeW-1:0];
    rt   = (fin_tok.remaining == fin_tok.burst) ?
           (now_q - sjf_pkg::TimeW'(fin_tok.arrival)) : fin_tok.response;
  end

  // control: time, running mark, tick sequencing, job count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_count_q    <= '0;
      now_q          <= '0;
      busy_q         <= 1'b0;
      go_q           <= 1'b0;
      cur_valid_q    <= 1'b0;
      cur_idx_q      <= '0;
      result_valid_o <= 1'b0;
    end else begin
      go_q           <= tick_acc;
      result_valid_o <= commit;
      if (cfg_valid_i && cfg_ready_o) begin
        job_count_q <= cfg_data_i;
      end
      if (tick_acc) begin
        busy_q <= 1'b1;
      end
      if (ld_acc && cur_valid_q && (CW'(cur_idx_q) == CW'(slot_i))) begin
        cur_valid_q <= 1'b0;
      end
      if (commit) begin
        busy_q      <= 1'b0;
        cur_valid_q <= fin_tok.found && !fin;
        cur_idx_q   <= fin_idx;
        if (now_q != sjf_pkg::TimeMax) begin
          now_q <= now_q + sjf_pkg::TimeW'(1);
        end
      end
    end
  end

  // result word register
  always_ff @(posedge clk_i) begin
    if (commit) begin
      tick_time_o       <= now_q;
      running_slot_o    <= fin_tok.found ? sjf_pkg::SlotW'(fin_idx) : '0;
      idle_o            <= !fin_tok.found;
      finished_o        <= fin;
      response_time_o   <= fin ? rt : '0;
      waiting_time_o    <= fin ? fin_tok.waiting : '0;
      turnaround_time_o <= fin ? tt : '0;
      all_done_o        <= (fin_tok.nd_cnt == sjf_pkg::NdNone) ||
                           ((fin_tok.nd_cnt == sjf_pkg::NdOne) && fin);
    end
  end

endmodule

>>> hw/rtl/sjf_cell.sv
// one job slot of the scheduler chain with its scan stage
module sjf_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        ld_en_i,
  input  logic [sjf_pkg::FieldW-1:0]  ld_arrival_i,
  input  logic [sjf_pkg::FieldW-1:0]  ld_burst_i,
  input  logic                        used_i,
  input  logic                        cur_hit_i,
  input  logic                        sel_hit_i,
  input  logic [sjf_pkg::TimeW-1:0]   now_i,
  input  sjf_pkg::cmt_t               cmt_i,
  input  logic                        tv_i,
  input  sjf_pkg::tok_t               tok_i,
  input  logic [IW-1:0]               tok_idx_i,
  output logic                        tv_o,
  output sjf_pkg::tok_t               tok_o,
  output logic [IW-1:0]               tok_idx_o
);

  logic [sjf_pkg::FieldW-1:0] arrival_q, burst_q, remaining_q;
  logic [sjf_pkg::TimeW-1:0]  response_q, waiting_q;
  logic                       done_q;
  logic                       tv_q;
  sjf_pkg::tok_t              tok_q, tok_d;
  logic [IW-1:0]              tok_idx_q, tok_idx_d;
  logic                       elig;

  assign elig = used_i && (sjf_pkg::TimeW'(arrival_q) <= now_i) && !done_q;

  // scan step: count unfinished slots and keep the best candidate
  always_comb begin
    tok_d     = tok_i;
    tok_idx_d = tok_idx_i;
    if (used_i && !done_q) begin
      case (tok_i.nd_cnt)
        sjf_pkg::NdNone: tok_d.nd_cnt = sjf_pkg::NdOne;
        default:         tok_d.nd_cnt = sjf_pkg::NdMany;
      endcase
    end
    if ((used_i && cur_hit_i && !done_q) ||
        (!tok_i.forced && elig && (!tok_i.found || burst_q < tok_i.burst))) begin
      tok_d.found     = 1'b1;
      tok_d.forced    = tok_i.forced | (used_i && cur_hit_i && !done_q);
      tok_d.arrival   = arrival_q;
      tok_d.burst     = burst_q;
      tok_d.remaining = remaining_q;
      tok_d.response  = response_q;
      tok_d.waiting   = waiting_q;
      tok_idx_d       = IW'(IDX);
    end
  end

  // scan stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tv_q <= 1'b0;
    end else begin
      tv_q <= tv_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tv_i) begin
      tok_q     <= tok_d;
      tok_idx_q <= tok_idx_d;
    end
  end

  // job fields without reset value
  always_ff @(posedge clk_i) begin
    if (ld_en_i) begin
      arrival_q   <= ld_arrival_i;
      burst_q     <= ld_burst_i;
      remaining_q <= ld_burst_i;
    end else if (cmt_i.en && sel_hit_i) begin
      if (remaining_q == burst_q) begin
        response_q <= now_i - sjf_pkg::TimeW'(arrival_q);
      end
      remaining_q <= remaining_q - sjf_pkg::FieldW'(1);
    end
  end

  // waiting count and done flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      waiting_q <= '0;
      done_q    <= 1'b0;
    end else if (ld_en_i) begin
      waiting_q <= '0;
      done_q    <= (ld_burst_i == '0);
    end else if (cmt_i.en) begin
      if (sel_hit_i) begin
        if (remaining_q == sjf_pkg::FieldW'(1)) begin
          done_q <= 1'b1;
        end
      end else if (cmt_i.found && elig && waiting_q != sjf_pkg::TimeMax) begin
        waiting_q <= waiting_q + sjf_pkg::TimeW'(1);
      end
    end
  end

  assign tv_o      = tv_q;
  assign tok_o     = tok_q;
  assign tok_idx_o = tok_idx_q;

endmodule
